// File: rtl/dhd_pkg.sv
// Package for the desk height decoder and drive: payload types, codes and reset values.
package dhd_pkg;

  localparam int WINDOW_BITS_DEF  = 32;
  localparam int PATTERN_BITS_DEF = 23;
  localparam int SYNC_W           = 23;
  localparam int HEIGHT_W         = 8;
  localparam int MARGIN_W         = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = SYNC_W;

  localparam logic [SYNC_W-1:0]   SYNC_PATTERN_RST     = SYNC_W'(6289917);
  localparam logic [HEIGHT_W-1:0] MAX_TARGET_RST       = HEIGHT_W'(113);
  localparam logic [MARGIN_W-1:0] UP_STOP_MARGIN_RST   = MARGIN_W'(1);
  localparam logic [MARGIN_W-1:0] DOWN_STOP_MARGIN_RST = MARGIN_W'(2);
  localparam logic [HEIGHT_W-1:0] MIN_VALID_HEIGHT_RST = HEIGHT_W'(60);
  localparam logic [HEIGHT_W-1:0] MAX_VALID_HEIGHT_RST = HEIGHT_W'(120);
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_STEP_RST  = HEIGHT_W'(5);

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_UP   = 2'd1,
    MOT_DOWN = 2'd2
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_PATTERN     = 3'd0,
    CFG_MAX_TARGET       = 3'd1,
    CFG_UP_STOP_MARGIN   = 3'd2,
    CFG_DOWN_STOP_MARGIN = 3'd3,
    CFG_MIN_VALID_HEIGHT = 3'd4,
    CFG_MAX_VALID_HEIGHT = 3'd5,
    CFG_MAX_HEIGHT_STEP  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                set_target;
    logic [HEIGHT_W-1:0] target_value;
    logic                sample_valid;
    logic                signal_bit;
    logic                up_switch_level;
    logic                down_switch_level;
  } dhd_in_t;

  typedef struct packed {
    logic                drive_up;
    logic                drive_down;
    logic [HEIGHT_W-1:0] current_height;
    logic [HEIGHT_W-1:0] target_height;
    logic                manual_override;
    logic                frame_matched;
  } dhd_out_t;

endpackage

// File: rtl/desk_height_decoder_and_drive.sv
// Desk height decoder and motor drive, one control pass per item.
//
// Usage:
//   in_valid/in_ready carry one control pass (target command, sampled height-bus
//   bit, hand switch levels). out_valid/out_ready return one result per pass:
//   drive directions, current and target height, override flag, frame match.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; cfg_ready is
//   always high; the user must write only while no item is in flight (not enforced).
// Path: an accepted item is registered at the input stage, worked by one
//   combinational pass against the state registers, and its result is
//   captured in the result register.
// Throughput: one item per cycle while out_ready stays high; the input register,
//   the state update and the result register all advance together.
// Stall: while out_ready is low the result holds, the input register keeps one
//   item, and in_ready drops once both are full.
// Reset: rst_n low clears the window, heights, motion and override, sets auto
//   mode, and loads the register defaults; no result is pending after reset.
module desk_height_decoder_and_drive import dhd_pkg::*; #(
  parameter int WINDOW_BITS  = WINDOW_BITS_DEF,
  parameter int PATTERN_BITS = PATTERN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dhd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dhd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SYNC_W-1:0]   sync_pattern_r;
  logic [HEIGHT_W-1:0] max_target_r;
  logic [MARGIN_W-1:0] up_margin_r;
  logic [MARGIN_W-1:0] down_margin_r;
  logic [HEIGHT_W-1:0] min_valid_r;
  logic [HEIGHT_W-1:0] max_valid_r;
  logic [HEIGHT_W-1:0] max_step_r;

  logic                in_valid_r;
  dhd_in_t             in_r;
  logic                out_valid_r;
  dhd_out_t            out_r;
  logic                advance;

  logic [WINDOW_BITS-1:0] window_r, window_nxt, window_shift;
  logic [HEIGHT_W-1:0]    height_r, height_nxt;
  logic [HEIGHT_W-1:0]    goal_r, goal_nxt;
  motion_t                motion_r, motion_nxt;
  logic                   ovr_r, ovr_nxt;
  logic                   auto_r, auto_nxt;
  logic                   matched_nxt;

  logic                   frame_hit;
  logic [HEIGHT_W-1:0]    frame_height;
  logic [HEIGHT_W-1:0]    step_abs;
  logic                   height_ok;
  logic [HEIGHT_W:0]      up_reach;
  logic [HEIGHT_W:0]      down_reach;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= SYNC_PATTERN_RST;
      max_target_r   <= MAX_TARGET_RST;
      up_margin_r    <= UP_STOP_MARGIN_RST;
      down_margin_r  <= DOWN_STOP_MARGIN_RST;
      min_valid_r    <= MIN_VALID_HEIGHT_RST;
      max_valid_r    <= MAX_VALID_HEIGHT_RST;
      max_step_r     <= MAX_HEIGHT_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_PATTERN:     sync_pattern_r <= cfg_data[SYNC_W-1:0];
        CFG_MAX_TARGET:       max_target_r   <= cfg_data[HEIGHT_W-1:0];
        CFG_UP_STOP_MARGIN:   up_margin_r    <= cfg_data[MARGIN_W-1:0];
        CFG_DOWN_STOP_MARGIN: down_margin_r  <= cfg_data[MARGIN_W-1:0];
        CFG_MIN_VALID_HEIGHT: min_valid_r    <= cfg_data[HEIGHT_W-1:0];
        CFG_MAX_VALID_HEIGHT: max_valid_r    <= cfg_data[HEIGHT_W-1:0];
        CFG_MAX_HEIGHT_STEP:  max_step_r     <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.drive_up        <= (motion_nxt == MOT_UP);
      out_r.drive_down      <= (motion_nxt == MOT_DOWN);
      out_r.current_height  <= height_nxt;
      out_r.target_height   <= goal_nxt;
      out_r.manual_override <= ovr_nxt;
      out_r.frame_matched   <= matched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      height_r <= '0;
      goal_r   <= '0;
      motion_r <= MOT_STOP;
      ovr_r    <= 1'b0;
      auto_r   <= 1'b1;
    end else if (advance) begin
      window_r <= window_nxt;
      height_r <= height_nxt;
      goal_r   <= goal_nxt;
      motion_r <= motion_nxt;
      ovr_r    <= ovr_nxt;
      auto_r   <= auto_nxt;
    end
  end

  assign window_shift = {in_r.signal_bit, window_r[WINDOW_BITS-1:1]};
  assign window_nxt   = in_r.sample_valid ? window_shift : window_r;

  dhd_frame #(
    .WINDOW_BITS  (WINDOW_BITS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_frame (
    .window  (window_shift),
    .pattern (sync_pattern_r),
    .matched (frame_hit),
    .height  (frame_height)
  );

  assign step_abs  = (height_r > frame_height) ? (height_r - frame_height)
                                               : (frame_height - height_r);
  assign height_ok = (frame_height >= min_valid_r) && (frame_height <= max_valid_r) &&
                     ((height_r == '0) || (step_abs < max_step_r));

  always_comb begin
    matched_nxt = in_r.sample_valid && frame_hit;
    height_nxt  = (matched_nxt && height_ok) ? frame_height : height_r;
    goal_nxt    = in_r.set_target ? in_r.target_value : goal_r;
    motion_nxt  = motion_r;
    ovr_nxt     = ovr_r;
    auto_nxt    = auto_r;

    if (in_r.set_target && !ovr_r) begin
      auto_nxt = 1'b1;
      if ((height_r < goal_nxt) && (goal_nxt < max_target_r)) begin
        motion_nxt = MOT_UP;
      end else if (height_r > goal_nxt) begin
        motion_nxt = MOT_DOWN;
      end
    end

    up_reach   = {1'b0, height_nxt} + {{(HEIGHT_W+1-MARGIN_W){1'b0}}, up_margin_r};
    down_reach = {1'b0, goal_nxt} + {{(HEIGHT_W+1-MARGIN_W){1'b0}}, down_margin_r};

    if (!ovr_r && auto_nxt) begin
      if ((motion_nxt == MOT_UP) && (up_reach >= {1'b0, goal_nxt})) begin
        motion_nxt = MOT_STOP;
        goal_nxt   = height_nxt;
      end
      if ((motion_nxt == MOT_DOWN) && ({1'b0, height_nxt} <= down_reach)) begin
        motion_nxt = MOT_STOP;
        goal_nxt   = height_nxt;
      end
    end

    if (ovr_r) begin
      if (in_r.up_switch_level && in_r.down_switch_level) begin
        motion_nxt = MOT_STOP;
        goal_nxt   = height_nxt;
        ovr_nxt    = 1'b0;
      end
    end else if (!in_r.up_switch_level) begin
      motion_nxt = MOT_UP;
      ovr_nxt    = 1'b1;
      auto_nxt   = 1'b0;
    end else if (!in_r.down_switch_level) begin
      motion_nxt = MOT_DOWN;
      ovr_nxt    = 1'b1;
      auto_nxt   = 1'b0;
    end
  end

endmodule

// File: rtl/dhd_frame.sv
// Frame matcher: compares the oldest window bits with the sync pattern and extracts the height.
module dhd_frame import dhd_pkg::*; #(
  parameter int WINDOW_BITS  = WINDOW_BITS_DEF,
  parameter int PATTERN_BITS = PATTERN_BITS_DEF
) (
  input  logic [WINDOW_BITS-1:0] window,
  input  logic [SYNC_W-1:0]      pattern,
  output logic                   matched,
  output logic [HEIGHT_W-1:0]    height
);

  logic [PATTERN_BITS-1:0] bit_eq;
  logic [HEIGHT_W-1:0]     raw;

  for (genvar i = 0; i < PATTERN_BITS; i++) begin : g_cmp
    if (i < SYNC_W) begin : g_pat
      assign bit_eq[i] = (window[i % WINDOW_BITS] == pattern[i]);
    end else begin : g_zero
      assign bit_eq[i] = !window[i % WINDOW_BITS];
    end
  end

  for (genvar i = 0; i < HEIGHT_W; i++) begin : g_raw
    assign raw[i] = window[(PATTERN_BITS + i) % WINDOW_BITS];
  end

  assign matched = &bit_eq;
  assign height  = ~raw;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for desk_height_decoder_and_drive: frame stimulus, predictor, checker.
module tb_top;
  import dhd_pkg::*;

  class desk_drive_board;
    logic [SYNC_W-1:0]   sync_pat;
    logic [HEIGHT_W-1:0] max_tgt;
    logic [MARGIN_W-1:0] up_mrg;
    logic [MARGIN_W-1:0] dn_mrg;
    logic [HEIGHT_W-1:0] min_h;
    logic [HEIGHT_W-1:0] max_h;
    logic [HEIGHT_W-1:0] max_step;
    logic [31:0]         window;
    logic [HEIGHT_W-1:0] height_now;
    logic [HEIGHT_W-1:0] height_goal;
    motion_t             motion;
    bit                  override_on;
    bit                  auto_on;
    dhd_out_t            pending_drives[$];
    int                  mismatches;
    int                  checked;
    int                  frames_matched;

    function new();
      sync_pat    = SYNC_PATTERN_RST;
      max_tgt     = MAX_TARGET_RST;
      up_mrg      = UP_STOP_MARGIN_RST;
      dn_mrg      = DOWN_STOP_MARGIN_RST;
      min_h       = MIN_VALID_HEIGHT_RST;
      max_h       = MAX_VALID_HEIGHT_RST;
      max_step    = MAX_HEIGHT_STEP_RST;
      window      = '0;
      height_now  = '0;
      height_goal = '0;
      motion      = MOT_STOP;
      override_on = 1'b0;
      auto_on     = 1'b1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [SYNC_W-1:0] v);
      case (idx)
        CFG_SYNC_PATTERN:     sync_pat = v;
        CFG_MAX_TARGET:       max_tgt  = v[HEIGHT_W-1:0];
        CFG_UP_STOP_MARGIN:   up_mrg   = v[MARGIN_W-1:0];
        CFG_DOWN_STOP_MARGIN: dn_mrg   = v[MARGIN_W-1:0];
        CFG_MIN_VALID_HEIGHT: min_h    = v[HEIGHT_W-1:0];
        CFG_MAX_VALID_HEIGHT: max_h    = v[HEIGHT_W-1:0];
        CFG_MAX_HEIGHT_STEP:  max_step = v[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void halt_drive();
      motion      = MOT_STOP;
      height_goal = height_now;
    endfunction

    function void note_pass(dhd_in_t p);
      bit                  matched;
      logic [HEIGHT_W-1:0] h;
      int                  diff;
      dhd_out_t            r;
      matched = 1'b0;
      if (p.set_target) begin
        height_goal = p.target_value;
        if (!override_on) begin
          auto_on = 1'b1;
          if (height_now < height_goal && height_goal < max_tgt) motion = MOT_UP;
          else if (height_now > height_goal) motion = MOT_DOWN;
        end
      end
      if (p.sample_valid) begin
        window = {p.signal_bit, window[31:1]};
        if (window[22:0] == sync_pat) begin
          matched = 1'b1;
          h = ~window[30:23];
          if (h >= min_h && h <= max_h) begin
            diff = int'(height_now) - int'(h);
            if (diff < 0) diff = -diff;
            if (height_now == 0 || diff < int'(max_step)) height_now = h;
          end
        end
      end
      if (!override_on && auto_on) begin
        if (motion == MOT_UP && int'(height_now) + int'(up_mrg) >= int'(height_goal))
          halt_drive();
        if (motion == MOT_DOWN && int'(height_now) - int'(dn_mrg) <= int'(height_goal))
          halt_drive();
      end
      if (override_on) begin
        if (p.up_switch_level && p.down_switch_level) begin
          halt_drive();
          override_on = 1'b0;
        end
      end else if (!p.up_switch_level) begin
        motion      = MOT_UP;
        override_on = 1'b1;
        auto_on     = 1'b0;
      end else if (!p.down_switch_level) begin
        motion      = MOT_DOWN;
        override_on = 1'b1;
        auto_on     = 1'b0;
      end
      r.drive_up        = (motion == MOT_UP);
      r.drive_down      = (motion == MOT_DOWN);
      r.current_height  = height_now;
      r.target_height   = height_goal;
      r.manual_override = override_on;
      r.frame_matched   = matched;
      if (matched) frames_matched++;
      pending_drives.push_back(r);
    endfunction

    function void check_result(dhd_out_t got);
      dhd_out_t exp;
      bit       bad;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: up=%0b dn=%0b h=%0d tgt=%0d ovr=%0b frm=%0b",
                   got.drive_up, got.drive_down, got.current_height, got.target_height,
                   got.manual_override, got.frame_matched);
        return;
      end
      exp = pending_drives.pop_front();
      checked++;
      bad = (got.drive_up !== exp.drive_up) || (got.drive_down !== exp.drive_down) ||
            (got.current_height !== exp.current_height) ||
            (got.target_height !== exp.target_height) ||
            (got.manual_override !== exp.manual_override) ||
            (got.frame_matched !== exp.frame_matched);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d, %0t:", checked, $realtime);
          $display("  exp up=%0b dn=%0b h=%0d tgt=%0d ovr=%0b frm=%0b",
                   exp.drive_up, exp.drive_down, exp.current_height, exp.target_height,
                   exp.manual_override, exp.frame_matched);
          $display("  got up=%0b dn=%0b h=%0d tgt=%0d ovr=%0b frm=%0b",
                   got.drive_up, got.drive_down, got.current_height, got.target_height,
                   got.manual_override, got.frame_matched);
        end
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  localparam int LONG_HOLD    = 150;
  localparam int PHASE_ITEMS  = 225;
  localparam int NUM_PHASES   = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  dhd_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  dhd_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  desk_height_decoder_and_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  desk_drive_board sb = new();

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int items_sent;
  int press_left;
  int press_kind;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #1600000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[desk_height_decoder_and_drive] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  function automatic dhd_in_t mk(bit st, logic [7:0] tv, bit sv, bit sbit, bit up, bit dn);
    dhd_in_t p;
    p.set_target        = st;
    p.target_value      = tv;
    p.sample_valid      = sv;
    p.signal_bit        = sbit;
    p.up_switch_level   = up;
    p.down_switch_level = dn;
    return p;
  endfunction

  function automatic logic [7:0] clamp_height(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic dhd_in_t make_pass(bit sv, bit sbit);
    dhd_in_t p;
    p = mk(($urandom_range(0, 24) == 0), 8'($urandom_range(0, 255)), sv, sbit, 1'b1, 1'b1);
    if (p.set_target && $urandom_range(0, 1) == 0)
      p.target_value = clamp_height(int'(sb.height_now) + $urandom_range(0, 60) - 30);
    if (press_left == 0 && $urandom_range(0, 59) == 0) begin
      press_left = $urandom_range(1, 6);
      press_kind = $urandom_range(0, 2);
    end
    if (press_left > 0) begin
      press_left--;
      p.up_switch_level   = (press_kind == 1);
      p.down_switch_level = (press_kind == 0);
    end
    return p;
  endfunction

  function automatic logic [7:0] pick_height();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (sb.height_now == 0 || r < 20) return 8'($urandom_range(0, 255));
    if (r < 40) return 8'($urandom_range(sb.min_h, sb.max_h));
    s = (sb.max_step > 20) ? 20 : ((sb.max_step == 0) ? 0 : sb.max_step - 1);
    return clamp_height(int'(sb.height_now) + $urandom_range(0, 2 * s) - s);
  endfunction

  task automatic send_pass(input dhd_in_t p);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_data  = p;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pass(p);
    items_sent++;
    @(negedge clk);
  endtask

  // Frame: sync bits, inverted height LSB first, one trailing bit; flip_at corrupts one bit.
  task automatic send_frame(input logic [7:0] h, input int flip_at, input int len);
    bit sbit;
    for (int i = 0; i < len; i++) begin
      if (i < 23) sbit = sb.sync_pat[i];
      else if (i < 31) sbit = ~h[i-23];
      else sbit = 1'($urandom_range(0, 1));
      if (i == flip_at) sbit = ~sbit;
      if ($urandom_range(0, 4) == 0) send_pass(make_pass(1'b0, 1'($urandom_range(0, 1))));
      send_pass(make_pass(1'b1, sbit));
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [SYNC_W-1:0] v);
    cfg_index = idx;
    cfg_data  = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_phase(input int ph);
    logic [SYNC_W-1:0] pat;
    logic [SYNC_W-1:0] vals [7];
    drain();
    repeat (3) @(negedge clk);
    pat = SYNC_W'($urandom_range(0, 23'h7FFFFF));
    case (ph)
      1: vals = '{pat, 200, 0, 0, 0, 255, 255};
      2: vals = '{23'h7FFFFF, 255, 15, 15, 60, 120, 10};
      3: vals = '{23'd0, 0, 3, 3, 100, 50, 5};
      4: vals = '{pat, 113, 1, 2, 60, 120, 0};
      5: vals = '{pat, 150, 15, 0, 0, 255, 1};
      6: vals = '{SYNC_PATTERN_RST, MAX_TARGET_RST, UP_STOP_MARGIN_RST, DOWN_STOP_MARGIN_RST,
                  MIN_VALID_HEIGHT_RST, MAX_VALID_HEIGHT_RST, MAX_HEIGHT_STEP_RST};
      default: vals = '{pat, 255, 7, 9, 40, 200, 30};
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), vals[i]);
  endtask

  initial begin
    int       stop_at;
    int       r;
    dhd_in_t  directed [$];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    items_sent = 0;
    press_left = 0;
    press_kind = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // targets at the extremes, overrides from either switch, both pressed, upper target limit
    directed = '{mk(0, 0, 0, 0, 1, 1),     mk(1, 255, 0, 0, 1, 1),   mk(1, 0, 0, 0, 1, 1),
                 mk(1, 50, 1, 1, 1, 1),    mk(0, 8'hAA, 1, 0, 1, 1), mk(0, 0, 0, 0, 0, 1),
                 mk(1, 100, 0, 0, 0, 1),   mk(0, 0, 0, 0, 1, 0),     mk(0, 0, 0, 0, 1, 1),
                 mk(0, 0, 0, 0, 1, 0),     mk(0, 0, 0, 0, 1, 1),     mk(0, 0, 0, 0, 0, 0),
                 mk(0, 0, 1, 1, 0, 0),     mk(0, 0, 0, 0, 1, 1),     mk(1, 112, 0, 0, 1, 1),
                 mk(1, 113, 0, 0, 1, 1),   mk(1, 0, 0, 0, 1, 1),     mk(1, 255, 1, 0, 0, 0),
                 mk(0, 255, 1, 1, 1, 1),   mk(0, 8'h55, 0, 1, 1, 1)};
    foreach (directed[i]) send_pass(directed[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) apply_phase(ph);
      tx_idle_on = (ph < NUM_PHASES - 1) && (ph != 4);
      rx_idle_on = (ph < NUM_PHASES - 1) && (ph != 5);
      stop_at = items_sent + PHASE_ITEMS;
      if (ph == 2) begin
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
        send_frame(pick_height(), -1, 32);
        tx_idle_on = 1'b1;
      end
      while (items_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_frame(pick_height(), -1, 32);
        else if (r < 80) send_frame(pick_height(), $urandom_range(0, 31), 32);
        else if (r < 87) send_frame(pick_height(), -1, $urandom_range(1, 31));
        else repeat ($urandom_range(1, 40)) send_pass(make_pass(1'b1, 1'($urandom_range(0, 1))));
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("covered %0d passes over %0d register settings, %0d frame matches",
             items_sent, NUM_PHASES, sb.frames_matched);
    $display("checked %0d results, %0d mismatches, %0d left over",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[desk_height_decoder_and_drive] OK");
    end else begin
      $display("[desk_height_decoder_and_drive] ERROR");
    end
    $finish;
  end

endmodule

// File: desk_height_decoder_and_drive.f
rtl/dhd_pkg.sv
rtl/dhd_frame.sv
rtl/desk_height_decoder_and_drive.sv
bench/tb_top.sv
